### design/two_key_short_long_press_detector_macros.svh
// Assertion macros for the two-key press detector.
// Each check is sampled on the rising edge of clk and held off during rst.
`ifndef TWO_KEY_SHORT_LONG_PRESS_DETECTOR_MACROS_SVH
`define TWO_KEY_SHORT_LONG_PRESS_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TKSL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tksl assertion failed");

// Next-cycle implication.
`define TKSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tksl assertion failed");

`else

`define TKSL_ASSERT_NOW(label, ante, cons)
`define TKSL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### design/tksl_pkg.sv
`timescale 1ns / 1ps

package tksl_pkg;

  localparam int TICK_BITS = 32;
  localparam int NOW_BITS  = 32;
  localparam int CFG_BITS  = 16;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [CFG_BITS-1:0]  cfg_word_t;

  localparam cfg_word_t SHORT_MIN_RESET  = 16'd20;
  localparam cfg_word_t LONG_PRESS_RESET = 16'd2000;

  // Register indexes on the configuration port.
  typedef enum logic {
    CFG_SHORT_MIN  = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_index_t;

  // Reported event codes.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_K1_SHORT = 3'd1,
    EV_K1_LONG  = 3'd2,
    EV_K2_SHORT = 3'd3,
    EV_K2_LONG  = 3'd4
  } press_code_t;

  // Thresholds shared by both key trackers.
  typedef struct packed {
    cfg_word_t short_min;
    cfg_word_t long_press;
  } thresh_t;

  // Per-key outcome of one scan.
  typedef struct packed {
    logic short_press;
    logic long_press;
  } key_evt_t;

endpackage

### design/tksl_key.sv
`timescale 1ns / 1ps

module tksl_key (
  input  logic              clk,
  input  logic              rst,
  input  logic              update,
  input  logic              down,
  input  tksl_pkg::tick_t   now,
  input  tksl_pkg::thresh_t thresh,
  output tksl_pkg::key_evt_t evt
);
  import tksl_pkg::*;

  logic  was_released;
  logic  long_seen;
  tick_t press_tick;
  tick_t held;

  // Wrapping difference gives held time across tick rollover.
  assign held = now - press_tick;

  always_comb begin
    evt = '0;
    if (down && !was_released) begin
      evt.long_press = !long_seen && (held >= tick_t'(thresh.long_press));
    end else if (!down && !was_released) begin
      evt.short_press = !long_seen && (held >= tick_t'(thresh.short_min));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_released <= 1'b1;
      long_seen    <= 1'b0;
      press_tick   <= '0;
    end else if (update) begin
      was_released <= !down;
      if (down && was_released) begin
        press_tick <= now;
        long_seen  <= 1'b0;
      end else if (evt.long_press) begin
        long_seen <= 1'b1;
      end
    end
  end

endmodule

### design/two_key_short_long_press_detector.sv
`timescale 1ns / 1ps
// Two-key short/long press detector.
// Input channel (in_valid / in_stall): one scan request per accepted item,
// carrying both key levels and the free-running tick count.
// Output channel (out_valid / out_stall): one key_event per scan, in order:
// 0 none, 1 key1 short, 2 key1 long, 3 key2 short, 4 key2 long.
// A key2 long press wins over any key1 event; key2 short only shows when
// key1 has nothing to report in the same scan.
// An accepted scan passes through an input register, then the key update and
// priority select into the result register. Throughput is one scan per cycle
// while the receiver does not stall; the input register can refill while the
// result register is drained in the same cycle.
// When the receiver stalls, the result holds, the input register holds, and
// in_stall rises once the input register is occupied.
// Reset (rst, synchronous) empties both stages, marks both keys released,
// clears the long flags and stored press ticks, and loads the default
// thresholds (short 20 ticks, long 2000 ticks). The user writes thresholds
// via cfg_wr_en/cfg_index/cfg_data only while idle, unchecked by the block.

module two_key_short_long_press_detector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_index,
  input  logic [tksl_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              key1_down,
  input  logic                              key2_down,
  input  logic [tksl_pkg::NOW_BITS-1:0]     now_ticks,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        key_event
);
  import tksl_pkg::*;

  // Configuration registers.
  thresh_t thresh;

  // Input stage.
  logic  s1_valid;
  logic  s1_key1;
  logic  s1_key2;
  tick_t s1_now;

  // Result stage.
  press_code_t result;
  press_code_t result_next;

  logic     advance;
  logic     s1_load;
  logic     s1_fire;
  key_evt_t evt1;
  key_evt_t evt2;

  // Result register frees up when empty or being taken this cycle.
  assign advance  = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh.short_min  <= SHORT_MIN_RESET;
      thresh.long_press <= LONG_PRESS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SHORT_MIN:  thresh.short_min  <= cfg_data;
        CFG_LONG_PRESS: thresh.long_press <= cfg_data;
        default:        thresh            <= thresh;
      endcase
    end
  end

  // Capture the scan request; hold it while the result side is blocked.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_key1 <= key1_down;
      s1_key2 <= key2_down;
      s1_now  <= tick_t'(now_ticks);
    end
  end

  // Per-key trackers advance their state only when the scan moves on.
  tksl_key u_key1 (
    .clk    (clk),
    .rst    (rst),
    .update (s1_fire),
    .down   (s1_key1),
    .now    (s1_now),
    .thresh (thresh),
    .evt    (evt1)
  );

  tksl_key u_key2 (
    .clk    (clk),
    .rst    (rst),
    .update (s1_fire),
    .down   (s1_key2),
    .now    (s1_now),
    .thresh (thresh),
    .evt    (evt2)
  );

  // Priority: key2 long, then key1 long, key1 short, key2 short.
  always_comb begin
    if (evt2.long_press) begin
      result_next = EV_K2_LONG;
    end else if (evt1.long_press) begin
      result_next = EV_K1_LONG;
    end else if (evt1.short_press) begin
      result_next = EV_K1_SHORT;
    end else if (evt2.short_press) begin
      result_next = EV_K2_SHORT;
    end else begin
      result_next = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= result_next;
    end
  end

  assign key_event = result;

`include "two_key_short_long_press_detector_macros.svh"

  // Back-pressure only when a scan is actually parked in the input stage.
  `TKSL_ASSERT_NOW(a_stall_needs_s1, in_stall, s1_valid)
  // A scan that moves on must show up as a result next cycle.
  `TKSL_ASSERT_NEXT(a_fire_gives_out, s1_fire, out_valid)
  // A key never reports short and long in the same scan.
  `TKSL_ASSERT_NOW(a_one_kind_per_key, s1_valid,
                   !(evt1.long_press && evt1.short_press) &&
                   !(evt2.long_press && evt2.short_press))

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tksl_pkg::*;

  // Give up once nothing has moved on either channel for this many cycles.
  localparam int QUIET_LIMIT = 1000;
  // Length of the long receiver hold-off used to fill the pipeline.
  localparam int LONG_HOLD   = 40;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic                cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic                key1_down;
  logic                key2_down;
  logic [NOW_BITS-1:0] now_ticks;
  logic                out_valid;
  logic                out_stall;
  logic [2:0]          key_event;

  two_key_short_long_press_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key1_down (key1_down),
    .key2_down (key2_down),
    .now_ticks (now_ticks),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_event (key_event)
  );

  // Shadow copy of the detector: per-key released flag, press tick and
  // long-press flag, plus the two thresholds as last written.
  bit         key_rel  [2];
  tick_t      key_t0   [2];
  bit         key_long [2];
  cfg_word_t  thr_short;
  cfg_word_t  thr_long;

  // Events predicted for accepted scan requests, oldest first.
  press_code_t pending_events[$];

  int n_errors;
  int quiet_cycles;

  // Idling controls, shared between the stimulus and the receiver process.
  bit tx_idle_on;
  bit rx_idle_on;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance one key by one scan and report whether it produced a short or a
  // long press. Held time wraps at the tick width.
  function automatic key_evt_t track_key(input bit k, input bit down, input tick_t now);
    key_evt_t r;
    tick_t    held;
    r    = '0;
    held = now - key_t0[k];
    if (down && key_rel[k]) begin
      // Press edge: latch the tick, arm a new long press.
      key_t0[k]   = now;
      key_long[k] = 1'b0;
    end else if (down) begin
      if (!key_long[k] && held >= tick_t'(thr_long)) begin
        key_long[k]     = 1'b1;
        r.long_press    = 1'b1;
      end
    end else if (!key_rel[k]) begin
      // Release: only a hold that never went long can count as short.
      if (!key_long[k] && held >= tick_t'(thr_short))
        r.short_press = 1'b1;
    end
    key_rel[k] = !down;
    return r;
  endfunction

  // Merge both keys into the one event of a scan. A key2 long press beats
  // anything from key1; a key2 short press only shows when key1 is silent.
  function automatic press_code_t scan_event(input bit k1, input bit k2, input tick_t now);
    key_evt_t    e1;
    key_evt_t    e2;
    press_code_t ev;
    e1 = track_key(1'b0, k1, now);
    e2 = track_key(1'b1, k2, now);
    ev = EV_NONE;
    if (e1.long_press)
      ev = EV_K1_LONG;
    else if (e1.short_press)
      ev = EV_K1_SHORT;
    if (e2.long_press)
      ev = EV_K2_LONG;
    else if (e2.short_press && ev == EV_NONE)
      ev = EV_K2_SHORT;
    return ev;
  endfunction

  // Predict on every accepted scan request. Inputs change only through
  // nonblocking updates, so the values seen here are the ones at the edge.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      pending_events.push_back(scan_event(key1_down, key2_down, now_ticks));
  end

  // Compare every accepted result against the oldest prediction.
  always @(posedge clk) begin : check_out
    press_code_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $display("%0t: key_event %0d with no scan pending", $time, key_event);
        n_errors++;
      end else begin
        want = pending_events.pop_front();
        if (key_event !== want) begin
          $display("%0t: key_event expected %0d (%s), got %0d",
                   $time, want, want.name(), key_event);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d events pending",
                 $time, QUIET_LIMIT, pending_events.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: hold off for a requested long stretch, otherwise stall in
  // short random bursts while idling is enabled.
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one scan request and hold it until accepted. Valid stays high on
  // return so that back-to-back requests need no extra edge.
  task automatic send_scan(input bit k1, input bit k2, input tick_t now);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    key1_down <= k1;
    key2_down <= k2;
    now_ticks <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted event has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  // Write both thresholds back to back; call only with the pipeline empty.
  task automatic set_thresholds(input cfg_word_t s_min, input cfg_word_t l_min);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SHORT_MIN;
    cfg_data  <= s_min;
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_data  <= l_min;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thr_short = s_min;
    thr_long  = l_min;
  endtask

  task automatic test_directed();
    // Reset thresholds: short 20, long 2000.
    send_scan(1'b0, 1'b0, 32'd0);
    send_scan(1'b1, 1'b0, 32'd100);
    send_scan(1'b0, 1'b0, 32'd119);          // one tick short of the minimum
    send_scan(1'b1, 1'b0, 32'd200);
    send_scan(1'b0, 1'b0, 32'd220);          // exactly the minimum
    send_scan(1'b0, 1'b1, 32'd300);
    send_scan(1'b0, 1'b1, 32'd2299);         // one tick short of long
    send_scan(1'b0, 1'b1, 32'd2300);         // long fires
    send_scan(1'b0, 1'b1, 32'd5000);         // no second long in one hold
    send_scan(1'b0, 1'b0, 32'd5001);         // release after long: silent
    // Both keys long across the tick wrap: key2 long wins.
    send_scan(1'b1, 1'b1, 32'hFFFF_FFF0);
    send_scan(1'b1, 1'b1, 32'h0000_07C0);
    send_scan(1'b0, 1'b0, 32'h0000_0800);
    // Both keys short in one scan: key1 short wins.
    send_scan(1'b1, 1'b1, 32'hFFFF_FFFF);
    send_scan(1'b0, 1'b0, 32'h0000_0020);
    // Key2 short alone, then key1 long beating a key2 short.
    send_scan(1'b0, 1'b1, 32'h0000_1000);
    send_scan(1'b1, 1'b1, 32'h0000_1001);
    send_scan(1'b1, 1'b0, 32'h0000_1100);
    send_scan(1'b1, 1'b1, 32'h0000_1200);
    send_scan(1'b1, 1'b0, 32'h0000_17D1);
    send_scan(1'b0, 1'b0, 32'h0000_17D2);
    // Zero thresholds: long fires on the first held scan, never on the
    // press edge; any release without long is a short.
    wait_drain();
    set_thresholds(16'd0, 16'd0);
    send_scan(1'b1, 1'b0, 32'h8000_0000);
    send_scan(1'b1, 1'b0, 32'h8000_0000);
    send_scan(1'b0, 1'b1, 32'h8000_0000);
    send_scan(1'b0, 1'b0, 32'h8000_0000);
    // Largest thresholds.
    wait_drain();
    set_thresholds(16'hFFFF, 16'hFFFF);
    send_scan(1'b1, 1'b0, 32'h0000_0010);
    send_scan(1'b1, 1'b0, 32'h0001_000F);
    send_scan(1'b0, 1'b1, 32'h0002_0000);
    send_scan(1'b0, 1'b0, 32'h0002_FFFE);
  endtask

  // Stall the receiver for a long stretch while requests keep coming, so the
  // block fills and raises in_stall; then pause until all has drained.
  task automatic test_backpressure();
    tick_t now;
    now = $urandom;
    hold_cycles = LONG_HOLD;
    repeat (12) begin
      now += $urandom_range(0, 8);
      send_scan(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), now);
    end
    wait_drain();
  endtask

  // Random press/release sequences under one threshold setting. Ticks mostly
  // advance in small steps; now and then they jump anywhere, and now and
  // then the sender pauses until the pipeline is empty.
  task automatic test_random(input int n_items, input cfg_word_t s_min,
                             input cfg_word_t l_min, input int max_step,
                             input tick_t start);
    tick_t now;
    bit    k1;
    bit    k2;
    wait_drain();
    set_thresholds(s_min, l_min);
    now = start;
    k1  = 1'b0;
    k2  = 1'b0;
    repeat (n_items) begin
      if ($urandom_range(0, 49) == 0)
        now = $urandom;
      else
        now += $urandom_range(0, max_step);
      if ($urandom_range(0, 3) == 0) k1 = ~k1;
      if ($urandom_range(0, 3) == 0) k2 = ~k2;
      if ($urandom_range(0, 59) == 0) wait_drain();
      send_scan(k1, k2, now);
    end
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= CFG_SHORT_MIN;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    key1_down  <= 1'b0;
    key2_down  <= 1'b0;
    now_ticks  <= '0;
    n_errors    = 0;
    hold_cycles = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    thr_short   = SHORT_MIN_RESET;
    thr_long    = LONG_PRESS_RESET;
    key_rel     = '{1'b1, 1'b1};
    key_t0      = '{'0, '0};
    key_long    = '{1'b0, 1'b0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(150, SHORT_MIN_RESET, LONG_PRESS_RESET, 1200, $urandom);
    test_random(150, 16'd5, 16'd40, 12, 32'hFFFF_FE00);
    test_random(100, 16'd0, 16'd1, 3, $urandom);
    test_random(100, 16'hFFFF, 16'hFFFF, 16'h6000, $urandom);
    test_random(100, cfg_word_t'($urandom_range(0, 100)),
                cfg_word_t'($urandom_range(0, 200)), 50, $urandom);

    // Closing stretch with no idling on either side.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random(100, 16'd10, 16'd100, 40, $urandom);

    wait_drain();
    repeat (10) @(posedge clk);
    if (n_errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/tksl_pkg.sv
design/tksl_key.sv
design/two_key_short_long_press_detector.sv
tb/tb_top.sv
